// ===== rtl/core/mlra_pkg.sv =====
// Shared types and codes for the max-level request aggregator.
// Used by the interfaces, the pool cell, the top level and the checker.
// Depends on nothing.
`default_nettype none

package mlra_pkg;

	// Fixed field widths.
	localparam int RES_W     = 3;
	localparam int MASK_W    = 8;
	localparam int STATUS_W  = 2;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 1;

	// Operation codes carried by a request.
	localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_REFRESH = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD_RES  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NO_USER  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LEVEL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENT_MASK  = 1'd1;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_NEXT = 4'b0010,
		S_SCAN = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	// Flags of the scan token that moves down the cell chain.
	typedef struct packed {
		logic vld;
		logic excl;
		logic hit;
		logic free;
	} chain_ctl_t;

	// Entry write command broadcast to all cells.
	typedef struct packed {
		logic en;
		logic clear;
	} wr_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/mlra_ifs.sv =====
// Handshake interfaces for the request and result channels.
// Depends on mlra_pkg for fixed field widths.
`default_nettype none

interface mlra_req_if #(
	parameter int USER_ID_WIDTH = 8,
	parameter int LEVEL_WIDTH   = 16
);
	logic                         valid;
	logic                         ready;
	logic [mlra_pkg::MODE_W-1:0]  mode;
	logic [mlra_pkg::RES_W-1:0]   resource_id;
	logic [USER_ID_WIDTH-1:0]     user_id;
	logic [LEVEL_WIDTH-1:0]       level;

	modport source (output valid, mode, resource_id, user_id, level, input ready);
	modport sink   (input valid, mode, resource_id, user_id, level, output ready);
endinterface

interface mlra_rsp_if #(
	parameter int LEVEL_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic [mlra_pkg::STATUS_W-1:0] status;
	logic [mlra_pkg::RES_W-1:0]    out_resource;
	logic [LEVEL_WIDTH-1:0]        agg_level;
	logic                          last;

	modport source (output valid, status, out_resource, agg_level, last, input ready);
	modport sink   (input valid, status, out_resource, agg_level, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mlra_cell.sv =====
// One pool entry of the aggregator and its stage of the scan chain.
// Depends on mlra_pkg for the token and write command structs.
`default_nettype none

module mlra_cell #(
	parameter int USER_ID_WIDTH = 8,
	parameter int LEVEL_WIDTH   = 16,
	parameter int IDX_W         = 4,
	parameter int IDX           = 0
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Query broadcast, held stable while a token is in flight.
	input  wire logic [mlra_pkg::RES_W-1:0]  qry_res,
	input  wire logic [USER_ID_WIDTH-1:0]    qry_user,
	// Token from the previous cell.
	input  wire mlra_pkg::chain_ctl_t        ctl_in,
	input  wire logic [LEVEL_WIDTH-1:0]      max_in,
	input  wire logic [IDX_W-1:0]            hidx_in,
	input  wire logic [IDX_W-1:0]            fidx_in,
	// Token to the next cell.
	output mlra_pkg::chain_ctl_t             ctl_out,
	output logic [LEVEL_WIDTH-1:0]           max_out,
	output logic [IDX_W-1:0]                 hidx_out,
	output logic [IDX_W-1:0]                 fidx_out,
	// Entry write command.
	input  wire mlra_pkg::wr_cmd_t           wr,
	input  wire logic [IDX_W-1:0]            wr_idx,
	input  wire logic [mlra_pkg::RES_W-1:0]  wr_res,
	input  wire logic [USER_ID_WIDTH-1:0]    wr_user,
	input  wire logic [LEVEL_WIDTH-1:0]      wr_level
);

	logic                       valid_q;
	logic [mlra_pkg::RES_W-1:0] res_q;
	logic [USER_ID_WIDTH-1:0]   user_q;
	logic [LEVEL_WIDTH-1:0]     level_q;

	mlra_pkg::chain_ctl_t       ctl_q;
	logic [LEVEL_WIDTH-1:0]     max_q;
	logic [IDX_W-1:0]           hidx_q;
	logic [IDX_W-1:0]           fidx_q;

	mlra_pkg::chain_ctl_t       ctl_n;
	logic [LEVEL_WIDTH-1:0]     max_n;
	logic [IDX_W-1:0]           hidx_n;
	logic [IDX_W-1:0]           fidx_n;
	logic                       sel;
	logic                       umatch;
	logic                       contrib;

	// Compare this entry against the query and fold it into the token.
	// The matching user is left out of the maximum when the token asks so,
	// since its level is about to be replaced or removed.
	always_comb begin
		sel     = valid_q && (res_q == qry_res);
		umatch  = sel && (user_q == qry_user);
		contrib = sel && !(ctl_in.excl && umatch);
		ctl_n   = ctl_in;
		max_n   = max_in;
		hidx_n  = hidx_in;
		fidx_n  = fidx_in;
		if (umatch && !ctl_in.hit) begin
			ctl_n.hit = 1'b1;
			hidx_n    = IDX_W'(IDX);
		end
		if (!valid_q && !ctl_in.free) begin
			ctl_n.free = 1'b1;
			fidx_n     = IDX_W'(IDX);
		end
		if (contrib && (level_q > max_in)) begin
			max_n = level_q;
		end
	end

	// Token stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_n;
		end
	end

	always_ff @(posedge clk) begin
		max_q  <= max_n;
		hidx_q <= hidx_n;
		fidx_q <= fidx_n;
	end

	// Entry storage, written when the command addresses this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && (wr_idx == IDX_W'(IDX))) begin
			valid_q <= !wr.clear;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && !wr.clear && (wr_idx == IDX_W'(IDX))) begin
			res_q   <= wr_res;
			user_q  <= wr_user;
			level_q <= wr_level;
		end
	end

	assign ctl_out  = ctl_q;
	assign max_out  = max_q;
	assign hidx_out = hidx_q;
	assign fidx_out = fidx_q;

endmodule

`default_nettype wire

// ===== rtl/core/max_level_request_aggregator.sv =====
// Flow: a request or release sends a token through the chain of pool cells, then
// enters the emit state; a read or unregistered-resource result goes from acceptance
// straight to the emit state. The emit state waits while the output is stalled and
// then loads the output register. The next request is taken only back in idle. A
// refresh scans each present resource in turn and steps over each absent index.
// Reset (arst_n low) clears every entry, the stored levels and the output.
`default_nettype none

// Top level: controller, configuration registers and the chain of pool cells.
// Depends on mlra_pkg, mlra_ifs and mlra_cell.
module max_level_request_aggregator #(
	parameter int POOL_ENTRIES  = 16,
	parameter int NUM_RESOURCES = 8,
	parameter int LEVEL_WIDTH   = 16,
	parameter int USER_ID_WIDTH = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [mlra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [((LEVEL_WIDTH > mlra_pkg::MASK_W) ? LEVEL_WIDTH
	                    : mlra_pkg::MASK_W)-1:0] cfg_data,
	mlra_req_if.sink                             req,
	mlra_rsp_if.source                           rsp
);

	localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int NRES  = (NUM_RESOURCES < mlra_pkg::MASK_W) ? NUM_RESOURCES
	                       : mlra_pkg::MASK_W;
	localparam int CIW   = (NRES > 1) ? $clog2(NRES) : 1;
	localparam int RES_W = mlra_pkg::RES_W;

	// Configuration registers.
	logic [LEVEL_WIDTH-1:0]       dflt_q;
	logic [mlra_pkg::MASK_W-1:0]  mask_q;

	// Controller state.
	mlra_pkg::state_t             state_q;
	logic                         inj_q;
	logic [mlra_pkg::MODE_W-1:0]  mode_q;
	logic [RES_W-1:0]             res_q;
	logic [USER_ID_WIDTH-1:0]     user_q;
	logic [LEVEL_WIDTH-1:0]       lvl_q;
	logic [LEVEL_WIDTH-1:0]       cur_q [0:NRES-1];

	// Pending result.
	logic [mlra_pkg::STATUS_W-1:0] rstat_q;
	logic [LEVEL_WIDTH-1:0]        rlev_q;
	logic                          rlast_q;

	// Output register.
	logic                          ovld_q;
	logic [mlra_pkg::STATUS_W-1:0] ostat_q;
	logic [RES_W-1:0]              ores_q;
	logic [LEVEL_WIDTH-1:0]        olev_q;
	logic                          olast_q;

	// Chain links.
	mlra_pkg::chain_ctl_t          lk_ctl  [0:POOL_ENTRIES];
	logic [LEVEL_WIDTH-1:0]        lk_max  [0:POOL_ENTRIES];
	logic [IDX_W-1:0]              lk_hidx [0:POOL_ENTRIES];
	logic [IDX_W-1:0]              lk_fidx [0:POOL_ENTRIES];

	mlra_pkg::wr_cmd_t             wr;
	logic [IDX_W-1:0]              wr_idx;
	mlra_pkg::chain_ctl_t          tail;
	logic [LEVEL_WIDTH-1:0]        tail_max;
	logic [LEVEL_WIDTH-1:0]        req_max;
	logic                          scan_done;
	logic                          pres_in;
	logic                          pres_cur;
	logic                          more_above;
	logic                          out_free;

	// A resource is present when it is below the resource count and its
	// mask bit is set.
	function automatic logic is_present(input logic [RES_W-1:0] r,
	                                    input logic [mlra_pkg::MASK_W-1:0] m);
		logic p;
		p = 1'b0;
		if (32'(r) < NRES) begin
			p = m[r];
		end
		return p;
	endfunction

	assign pres_in  = is_present(req.resource_id, mask_q);
	assign pres_cur = is_present(res_q, mask_q);

	// Any present resource above the current one ends a refresh run later.
	always_comb begin
		more_above = 1'b0;
		for (int j = 0; j < mlra_pkg::MASK_W; j++) begin
			if ((RES_W'(j) > res_q) && (j < NRES) && mask_q[j]) begin
				more_above = 1'b1;
			end
		end
	end

	// Token entering the first cell.
	assign lk_ctl[0]  = '{vld: inj_q, excl: (mode_q != mlra_pkg::MODE_REFRESH),
	                      hit: 1'b0, free: 1'b0};
	assign lk_max[0]  = dflt_q;
	assign lk_hidx[0] = '0;
	assign lk_fidx[0] = '0;

	// Chain of pool cells.
	for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
		mlra_cell #(
			.USER_ID_WIDTH (USER_ID_WIDTH),
			.LEVEL_WIDTH   (LEVEL_WIDTH),
			.IDX_W         (IDX_W),
			.IDX           (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.qry_res  (res_q),
			.qry_user (user_q),
			.ctl_in   (lk_ctl[i]),
			.max_in   (lk_max[i]),
			.hidx_in  (lk_hidx[i]),
			.fidx_in  (lk_fidx[i]),
			.ctl_out  (lk_ctl[i+1]),
			.max_out  (lk_max[i+1]),
			.hidx_out (lk_hidx[i+1]),
			.fidx_out (lk_fidx[i+1]),
			.wr       (wr),
			.wr_idx   (wr_idx),
			.wr_res   (res_q),
			.wr_user  (user_q),
			.wr_level (lvl_q)
		);
	end

	// Token leaving the last cell and the entry update it decides.
	assign tail      = lk_ctl[POOL_ENTRIES];
	assign tail_max  = lk_max[POOL_ENTRIES];
	assign scan_done = (state_q == mlra_pkg::S_SCAN) && tail.vld;
	assign req_max   = (tail_max > lvl_q) ? tail_max : lvl_q;
	assign wr        = '{en: scan_done &&
	                     (((mode_q == mlra_pkg::MODE_REQUEST) && (tail.hit || tail.free)) ||
	                      ((mode_q == mlra_pkg::MODE_RELEASE) && tail.hit)),
	                     clear: (mode_q == mlra_pkg::MODE_RELEASE)};
	assign wr_idx    = tail.hit ? lk_hidx[POOL_ENTRIES] : lk_fidx[POOL_ENTRIES];

	assign out_free  = !ovld_q || rsp.ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q <= '0;
			mask_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				mlra_pkg::CFG_DEFAULT_LEVEL: dflt_q <= cfg_data[LEVEL_WIDTH-1:0];
				mlra_pkg::CFG_PRESENT_MASK:  mask_q <= cfg_data[mlra_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Controller: accept, walk the chain, update the entry and report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlra_pkg::S_IDLE;
			inj_q   <= 1'b0;
			for (int k = 0; k < NRES; k++) begin
				cur_q[k] <= '0;
			end
		end else begin
			inj_q <= 1'b0;
			case (state_q)
				mlra_pkg::S_IDLE: begin
					if (req.valid) begin
						if (req.mode == mlra_pkg::MODE_REFRESH) begin
							state_q <= mlra_pkg::S_NEXT;
						end else if (!pres_in) begin
							state_q <= mlra_pkg::S_EMIT;
						end else if (req.mode == mlra_pkg::MODE_READ) begin
							state_q <= mlra_pkg::S_EMIT;
						end else begin
							inj_q   <= 1'b1;
							state_q <= mlra_pkg::S_SCAN;
						end
					end
				end
				mlra_pkg::S_NEXT: begin
					if (pres_cur) begin
						inj_q   <= 1'b1;
						state_q <= mlra_pkg::S_SCAN;
					end else if (res_q == RES_W'(NRES - 1)) begin
						state_q <= mlra_pkg::S_IDLE;
					end
				end
				mlra_pkg::S_SCAN: begin
					if (scan_done) begin
						state_q <= mlra_pkg::S_EMIT;
						if (mode_q == mlra_pkg::MODE_REFRESH) begin
							cur_q[res_q[CIW-1:0]] <= tail_max;
						end else if (wr.en) begin
							cur_q[res_q[CIW-1:0]] <= wr.clear ? tail_max : req_max;
						end
					end
				end
				mlra_pkg::S_EMIT: begin
					if (out_free) begin
						if ((mode_q == mlra_pkg::MODE_REFRESH) && !rlast_q) begin
							state_q <= mlra_pkg::S_NEXT;
						end else begin
							state_q <= mlra_pkg::S_IDLE;
						end
					end
				end
				default: state_q <= mlra_pkg::S_IDLE;
			endcase
		end
	end

	// Request fields, scan resource and pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			mlra_pkg::S_IDLE: begin
				if (req.valid) begin
					mode_q  <= req.mode;
					res_q   <= (req.mode == mlra_pkg::MODE_REFRESH) ? '0 : req.resource_id;
					user_q  <= req.user_id;
					lvl_q   <= req.level;
					rlast_q <= 1'b1;
					rlev_q  <= '0;
					if (!pres_in) begin
						rstat_q <= mlra_pkg::STAT_BAD_RES;
					end else begin
						rstat_q <= mlra_pkg::STAT_OK;
						rlev_q  <= cur_q[req.resource_id[CIW-1:0]];
					end
				end
			end
			mlra_pkg::S_NEXT: begin
				if (!pres_cur && (res_q != RES_W'(NRES - 1))) begin
					res_q <= res_q + 1'b1;
				end
			end
			mlra_pkg::S_SCAN: begin
				if (scan_done) begin
					case (mode_q)
						mlra_pkg::MODE_REFRESH: begin
							rstat_q <= mlra_pkg::STAT_OK;
							rlev_q  <= tail_max;
							rlast_q <= !more_above;
						end
						mlra_pkg::MODE_REQUEST: begin
							rstat_q <= wr.en ? mlra_pkg::STAT_OK : mlra_pkg::STAT_FULL;
							rlev_q  <= wr.en ? req_max : '0;
							rlast_q <= 1'b1;
						end
						default: begin
							rstat_q <= wr.en ? mlra_pkg::STAT_OK : mlra_pkg::STAT_NO_USER;
							rlev_q  <= wr.en ? tail_max : '0;
							rlast_q <= 1'b1;
						end
					endcase
				end
			end
			mlra_pkg::S_EMIT: begin
				if (out_free && (mode_q == mlra_pkg::MODE_REFRESH) && !rlast_q) begin
					res_q <= res_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if ((state_q == mlra_pkg::S_EMIT) && out_free) begin
			ovld_q <= 1'b1;
		end else if (rsp.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == mlra_pkg::S_EMIT) && out_free) begin
			ostat_q <= rstat_q;
			ores_q  <= res_q;
			olev_q  <= rlev_q;
			olast_q <= rlast_q;
		end
	end

	assign req.ready        = (state_q == mlra_pkg::S_IDLE);
	assign rsp.valid        = ovld_q;
	assign rsp.status       = ostat_q;
	assign rsp.out_resource = ores_q;
	assign rsp.agg_level    = olev_q;
	assign rsp.last         = olast_q;

endmodule

`default_nettype wire

// ===== rtl/core/mlra_checker.sv =====
// Port-level checks for the max-level request aggregator, bound to its top.
// Depends on mlra_pkg for status codes.
`default_nettype none

module mlra_checker #(
	parameter int LEVEL_WIDTH = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [mlra_pkg::STATUS_W-1:0] rsp_status,
	input wire logic [LEVEL_WIDTH-1:0]        rsp_level,
	input wire logic                          rsp_last
);

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// Error results carry a zero level and end the run.
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != mlra_pkg::STAT_OK) |-> rsp_last && (rsp_level == '0))
		else $error("error result with nonzero level or without last");

	// Only refresh runs have results before the last, and those are ok.
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_status == mlra_pkg::STAT_OK)
		else $error("intermediate result with error status");

	// One request at a time: the input is not ready in the cycle after an acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in work");

endmodule

bind max_level_request_aggregator mlra_checker #(
	.LEVEL_WIDTH (LEVEL_WIDTH)
) u_mlra_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_level  (rsp.agg_level),
	.rsp_last   (rsp.last)
);

`default_nettype wire
